FILE: rtl/core/sga_pkg.sv
package sga_pkg;

  // Table bound: counts saturate here and positions at one below it
  localparam int MAX_RECORDS = 65536;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int POS_W = 16;
  localparam int CNT_W = 17;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);
  localparam logic [CNT_W-1:0] IDX_LIM = CNT_W'(MAX_RECORDS - 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_RECORDS - 1);

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 104;

  localparam int DIV_STEPS = VAL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_MAX = 2'd0,
    MODE_MIN = 2'd1,
    MODE_SUM = 2'd2,
    MODE_AVG = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_LOAD
  } fsm_t;

  // Which closed-group snapshot feeds the divider and the output stage
  typedef enum logic {
    SNAP_CLOSE = 1'b0,
    SNAP_FINAL = 1'b1
  } snap_t;

  typedef struct packed {
    logic  accept;
    logic  div_start;
    logic  out_load;
    snap_t sel;
  } sga_cmd_t;

  typedef struct packed {
    logic close;
    logic eot;
    logic avg;
    logic slot_free;
    logic div_done;
  } sga_sts_t;

endpackage

FILE: rtl/core/sga_div.sv
module sga_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [sga_pkg::VAL_W-1:0]    dividend,
  input  logic        [sga_pkg::CNT_W-1:0]    divisor,
  output logic                                done,
  output logic signed [sga_pkg::VAL_W-1:0]    quotient
);

  logic                             busy_r, busy_nxt;
  logic [sga_pkg::DIV_CNT_W-1:0]    step_r, step_nxt;
  logic                             neg_r, neg_nxt;
  logic [sga_pkg::VAL_W-1:0]        mag_r, mag_nxt;
  logic [sga_pkg::CNT_W-1:0]        rem_r, rem_nxt;
  logic [sga_pkg::CNT_W-1:0]        div_r, div_nxt;
  logic [sga_pkg::CNT_W:0]          rem_sh;
  logic [sga_pkg::CNT_W:0]          rem_diff;
  logic                             q_bit;

  localparam logic [sga_pkg::DIV_CNT_W-1:0] LAST_STEP =
    sga_pkg::DIV_CNT_W'(sga_pkg::DIV_STEPS - 1);

  // One restoring step a cycle: shift in the next dividend bit, try subtract
  assign rem_sh   = {rem_r, mag_r[sga_pkg::VAL_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign q_bit    = (rem_sh >= {1'b0, div_r});

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      neg_nxt  = dividend[sga_pkg::VAL_W-1];
      mag_nxt  = dividend[sga_pkg::VAL_W-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      mag_nxt  = {mag_r[sga_pkg::VAL_W-2:0], q_bit};
      rem_nxt  = q_bit ? rem_diff[sga_pkg::CNT_W-1:0] : rem_sh[sga_pkg::CNT_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = busy_r && (step_r == LAST_STEP);
  assign quotient = neg_r ? $signed(~mag_r + 1'b1) : $signed(mag_r);

endmodule

FILE: rtl/core/sga_dp.sv
module sga_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sga_pkg::sga_cmd_t                     cmd,
  output sga_pkg::sga_sts_t                     sts,
  input  logic                                  cfg_valid,
  input  logic [1:0]                            cfg_data,
  input  logic [sga_pkg::IN_DATA_W-1:0]         in_tdata,
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [sga_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tlast
);

  sga_pkg::mode_t mode_r;

  // Open group
  logic                              have_r, have_nxt;
  logic signed [sga_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic        [sga_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic        [sga_pkg::POS_W-1:0]  first_r, first_nxt;
  logic        [sga_pkg::CNT_W-1:0]  size_r, size_nxt;
  logic signed [sga_pkg::VAL_W-1:0]  agg_r, agg_nxt;

  // Snapshots of closed groups, indexed by snap_t
  logic signed [sga_pkg::KEY_W-1:0]  snap_key_r   [2];
  logic        [sga_pkg::POS_W-1:0]  snap_first_r [2];
  logic        [sga_pkg::CNT_W-1:0]  snap_size_r  [2];
  logic signed [sga_pkg::VAL_W-1:0]  snap_agg_r   [2];

  logic                              out_valid_r;
  logic [sga_pkg::OUT_DATA_W-1:0]    out_data_r;
  logic                              out_last_r;

  logic signed [sga_pkg::KEY_W-1:0]  in_key;
  logic signed [sga_pkg::VAL_W-1:0]  in_val;
  logic                              close;
  logic        [sga_pkg::POS_W-1:0]  upd_first;
  logic        [sga_pkg::CNT_W-1:0]  upd_size;
  logic signed [sga_pkg::VAL_W-1:0]  upd_agg;
  logic signed [sga_pkg::VAL_W-1:0]  res_agg;
  logic                              div_done;
  logic signed [sga_pkg::VAL_W-1:0]  quotient;

  assign in_key = in_tdata[sga_pkg::KEY_W-1:0];
  assign in_val = in_tdata[sga_pkg::KEY_W +: sga_pkg::VAL_W];
  assign close  = have_r && (in_key != key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sga_pkg::MODE_MAX;
    end else if (cfg_valid) begin
      mode_r <= sga_pkg::mode_t'(cfg_data);
    end
  end

  // Group with this record folded in
  always_comb begin
    if (!have_r || close) begin
      upd_first = (idx_r < sga_pkg::IDX_LIM) ? idx_r[sga_pkg::POS_W-1:0] : sga_pkg::POS_MAX;
      upd_size  = sga_pkg::CNT_W'(1);
      upd_agg   = in_val;
    end else begin
      upd_first = first_r;
      upd_size  = (size_r < sga_pkg::CNT_MAX) ? size_r + 1'b1 : size_r;
      case (mode_r) inside
        sga_pkg::MODE_MAX:           upd_agg = (in_val > agg_r) ? in_val : agg_r;
        sga_pkg::MODE_MIN:           upd_agg = (in_val < agg_r) ? in_val : agg_r;
        sga_pkg::MODE_SUM,
        sga_pkg::MODE_AVG:           upd_agg = agg_r + in_val;
        default:                     upd_agg = agg_r;
      endcase
    end
  end

  always_comb begin
    have_nxt  = have_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    size_nxt  = size_r;
    agg_nxt   = agg_r;
    if (cmd.accept) begin
      if (in_tlast) begin
        have_nxt  = 1'b0;
        key_nxt   = '0;
        idx_nxt   = '0;
        first_nxt = '0;
        size_nxt  = '0;
        agg_nxt   = '0;
      end else begin
        have_nxt  = 1'b1;
        key_nxt   = in_key;
        idx_nxt   = (idx_r < sga_pkg::CNT_MAX) ? idx_r + 1'b1 : idx_r;
        first_nxt = upd_first;
        size_nxt  = upd_size;
        agg_nxt   = upd_agg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r  <= 1'b0;
      key_r   <= '0;
      idx_r   <= '0;
      first_r <= '0;
      size_r  <= '0;
      agg_r   <= '0;
    end else begin
      have_r  <= have_nxt;
      key_r   <= key_nxt;
      idx_r   <= idx_nxt;
      first_r <= first_nxt;
      size_r  <= size_nxt;
      agg_r   <= agg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && close) begin
      snap_key_r[sga_pkg::SNAP_CLOSE]   <= key_r;
      snap_first_r[sga_pkg::SNAP_CLOSE] <= first_r;
      snap_size_r[sga_pkg::SNAP_CLOSE]  <= size_r;
      snap_agg_r[sga_pkg::SNAP_CLOSE]   <= agg_r;
    end
    if (cmd.accept && in_tlast) begin
      snap_key_r[sga_pkg::SNAP_FINAL]   <= in_key;
      snap_first_r[sga_pkg::SNAP_FINAL] <= upd_first;
      snap_size_r[sga_pkg::SNAP_FINAL]  <= upd_size;
      snap_agg_r[sga_pkg::SNAP_FINAL]   <= upd_agg;
    end
  end

  sga_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (snap_agg_r[cmd.sel]),
    .divisor  (snap_size_r[cmd.sel]),
    .done     (div_done),
    .quotient (quotient)
  );

  assign res_agg = (mode_r == sga_pkg::MODE_AVG) ? quotient : snap_agg_r[cmd.sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= {7'd0, res_agg, snap_size_r[cmd.sel], snap_first_r[cmd.sel],
                     snap_key_r[cmd.sel]};
      out_last_r <= (cmd.sel == sga_pkg::SNAP_FINAL);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign sts.close     = close;
  assign sts.eot       = in_tlast;
  assign sts.avg       = (mode_r == sga_pkg::MODE_AVG);
  assign sts.slot_free = !out_valid_r || out_tready;
  assign sts.div_done  = div_done;

endmodule

FILE: rtl/core/sga_ctrl.sv
module sga_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  sga_pkg::sga_sts_t  sts,
  output sga_pkg::sga_cmd_t  cmd
);

  sga_pkg::fsm_t  state_r, state_nxt;
  sga_pkg::snap_t sel_r, sel_nxt;
  logic           pend_r, pend_nxt;
  logic           accept;

  assign accept = in_tvalid && (state_r == sga_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    pend_nxt  = pend_r;
    unique case (state_r)
      sga_pkg::ST_IDLE: begin
        if (accept && (sts.close || sts.eot)) begin
          sel_nxt   = sts.close ? sga_pkg::SNAP_CLOSE : sga_pkg::SNAP_FINAL;
          pend_nxt  = sts.close && sts.eot;
          state_nxt = sts.avg ? sga_pkg::ST_DIV_GO : sga_pkg::ST_LOAD;
        end
      end
      sga_pkg::ST_DIV_GO: begin
        state_nxt = sga_pkg::ST_DIV_WAIT;
      end
      sga_pkg::ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = sga_pkg::ST_LOAD;
        end
      end
      sga_pkg::ST_LOAD: begin
        if (sts.slot_free) begin
          if (pend_r) begin
            sel_nxt   = sga_pkg::SNAP_FINAL;
            pend_nxt  = 1'b0;
            state_nxt = sts.avg ? sga_pkg::ST_DIV_GO : sga_pkg::ST_LOAD;
          end else begin
            state_nxt = sga_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sga_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.accept    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.sel       = sel_r;
    in_tready     = 1'b0;
    unique case (state_r)
      sga_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      sga_pkg::ST_DIV_GO:   cmd.div_start = 1'b1;
      sga_pkg::ST_DIV_WAIT: cmd.div_start = 1'b0;
      sga_pkg::ST_LOAD:     cmd.out_load  = sts.slot_free;
      default:              cmd.out_load  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sga_pkg::ST_IDLE;
      sel_r   <= sga_pkg::SNAP_CLOSE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

FILE: rtl/core/sorted_group_aggregate.sv
// Channel  Direction  Beat contents
// -------  ---------  ---------------------------------------------------------
// in_      slave      tdata: group_key, agg_value; tlast: end_of_table
// out_     master     tdata: out_key, start_position, record_count, aggregate;
//                     tlast: last_group
// cfg_     slave      data: agg_mode (2 bits), no address
//
// A record that neither changes the key nor ends the table is folded in directly,
// so such runs stream at one beat per clock while the controller is idle. A record
// that closes a group stalls the input until each result is loaded, and in average
// mode also while the one-bit-a-cycle divider works out each mean.
// Synchronous active-low reset clears the open group and sets mode to maximum.
// The output register holds a result while out_tready is low; input is taken
// meanwhile and stalls only when a further result finds the register full.
module sorted_group_aggregate (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_data,   // [1:0] agg_mode
  // records in
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [sga_pkg::IN_DATA_W-1:0]        in_tdata,   // [31:0] group_key,
                                                           // [63:32] agg_value
  input  logic                                 in_tlast,
  // group results out
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sga_pkg::OUT_DATA_W-1:0]       out_tdata,  // [31:0] out_key,
                                                           // [47:32] start_position,
                                                           // [64:48] record_count,
                                                           // [96:65] aggregate,
                                                           // [103:97] zero
  output logic                                 out_tlast
);

  sga_pkg::sga_cmd_t cmd;
  sga_pkg::sga_sts_t sts;

  // Mode writes are always taken; callers write only while idle
  assign cfg_ready = 1'b1;

  sga_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sga_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
